// ===== sv/idll_pkg.sv =====
// shared constants and codes of the indexed doubly linked list
`default_nettype none

package idll_pkg;

  localparam int DefCapacity  = 64;
  localparam int DefValueBits = 32;

  localparam int OpcodeBits  = 2;
  localparam int PosBits     = 7;
  localparam int ItemBits    = 32;
  localparam int StatusBits  = 2;
  localparam int LenBits     = 7;
  localparam int InDataBits  = 48;
  localparam int OutDataBits = 48;

  // input word layout
  localparam int InPosLsb  = OpcodeBits;
  localparam int InValLsb  = InPosLsb + PosBits;
  localparam int InUsed    = InValLsb + ItemBits;
  // result word layout
  localparam int OutRdLsb  = StatusBits;
  localparam int OutLenLsb = OutRdLsb + ItemBits;
  localparam int OutEmpty  = OutLenLsb + LenBits;
  localparam int OutUsed   = OutEmpty + 1;

  typedef enum logic [OpcodeBits-1:0] {
    OP_READ   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic [StatusBits-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_POP,
    S_INS1,
    S_INS2,
    S_INS3,
    S_DEL1,
    S_DEL2,
    S_DEL3,
    S_FIN
  } state_e;

endpackage

`default_nettype wire

// ===== sv/indexed_doubly_linked_list_top.sv =====
// indexed doubly linked list: ordered value list in a node memory with head sentinel
//
// Requests arrive as words on the s_axis channel, one result word per request leaves on
// m_axis. A request reads, inserts or deletes at a zero-based position, or clears the list.
// The list sits in one node memory (value, next, prev per slot); the sentinel links live in
// registers. Freed slots form a free list chained through their next field, and slots never
// used since the last clear are handed out by a fill count, so clear only resets registers.
// Requests are handled one at a time; a position walk starts at the head or the tail
// and follows at most count/2 links.
// The walk follows one link per cycle through the memory's single read port; each link
// read feeds the next read address straight from the registered read data.
// Relinking takes one memory write per cycle.
// The result sits in an output register; the next request is accepted while it waits,
// and only the final step of that request stalls until the register is free.
// Reset empties the list and marks every slot free; the node memory itself is not cleared.
`default_nettype none

module indexed_doubly_linked_list_top #(
  parameter int CAPACITY   = idll_pkg::DefCapacity,
  parameter int VALUE_BITS = idll_pkg::DefValueBits
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // opcode [1:0], position [8:2], item_value [40:9], zero fill
  input  wire logic [idll_pkg::InDataBits-1:0]  s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // status [1:0], read_value [33:2], length [40:34], is_empty [41], zero fill
  output logic [idll_pkg::OutDataBits-1:0]      m_axis_tdata
);
  import idll_pkg::*;

  localparam int LW   = $clog2(CAPACITY + 1);
  localparam int CW   = LW;
  localparam int AW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > PosBits) ? CW : PosBits;
  localparam logic [LW-1:0] SENT    = LW'(CAPACITY);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  typedef struct packed {
    logic [LW-1:0]         prv;
    logic [LW-1:0]         nxt;
    logic [VALUE_BITS-1:0] val;
  } node_t;

  typedef struct packed {
    logic                  re;
    logic [AW-1:0]         ra;
    logic                  we_val;
    logic                  we_nxt;
    logic                  we_prv;
    logic [AW-1:0]         wa;
    node_t                 wd;
  } mem_ctl_t;

  // node memory
  node_t    node_mem [CAPACITY];
  node_t    rd_entry_q;
  mem_ctl_t mc;

  always_ff @(posedge clk_i) begin
    if (mc.we_val) node_mem[mc.wa].val <= mc.wd.val;
    if (mc.we_nxt) node_mem[mc.wa].nxt <= mc.wd.nxt;
    if (mc.we_prv) node_mem[mc.wa].prv <= mc.wd.prv;
    if (mc.re) rd_entry_q <= node_mem[mc.ra];
  end

  state_e                state_q, state_d;
  logic [LW-1:0]         head_q, head_d, tail_q, tail_d, flh_q, flh_d;
  logic [CW-1:0]         count_q, count_d, hw_q, hw_d, rem_q, rem_d;
  opcode_e               op_q, op_d;
  logic                  front_q, front_d;
  logic [LW-1:0]         cur_q, cur_d, nx_q, nx_d, pv_q, pv_d, slot_q, slot_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  status_e               res_st_q, res_st_d;
  logic [ItemBits-1:0]   res_rd_q, res_rd_d;
  logic                  m_valid_q, m_valid_d;
  logic [OutDataBits-1:0] m_data_q, m_data_d;

  opcode_e               in_op;
  logic [PosBits-1:0]    in_pos;
  logic [ItemBits-1:0]   in_val;
  logic [CMPW-1:0]       pos_x, cnt_x, steps_x;
  logic                  in_front;
  logic [LW-1:0]         start_id, walk_next;
  logic                  out_free, pop;

  assign in_op    = opcode_e'(s_axis_tdata[OpcodeBits-1:0]);
  assign in_pos   = s_axis_tdata[InValLsb-1:InPosLsb];
  assign in_val   = s_axis_tdata[InUsed-1:InValLsb];
  assign pos_x    = CMPW'(in_pos);
  assign cnt_x    = CMPW'(count_q);
  assign in_front = (pos_x <= (cnt_x >> 1));
  assign steps_x  = in_front ? pos_x : (cnt_x - pos_x - CMPW'(1));
  assign start_id = in_front ? head_q : tail_q;
  assign walk_next = front_q ? rd_entry_q.nxt : rd_entry_q.prv;
  assign out_free = !m_valid_q || m_axis_tready;
  // reuse a freed slot while any exist, else take the next never-used one
  assign pop      = (hw_q > count_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    flh_d     = flh_q;
    count_d   = count_q;
    hw_d      = hw_q;
    rem_d     = rem_q;
    op_d      = op_q;
    front_d   = front_q;
    cur_d     = cur_q;
    nx_d      = nx_q;
    pv_d      = pv_q;
    slot_d    = slot_q;
    val_d     = val_q;
    res_st_d  = res_st_q;
    res_rd_d  = res_rd_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    mc        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d     = in_op;
          val_d    = VALUE_BITS'(in_val);
          front_d  = in_front;
          res_st_d = ST_OK;
          res_rd_d = '0;
          state_d  = S_FIN;
          unique case (in_op)
            OP_READ, OP_DELETE: begin
              if (pos_x >= cnt_x) begin
                res_st_d = ST_RANGE;
              end else begin
                mc.re   = 1'b1;
                mc.ra   = start_id[AW-1:0];
                cur_d   = start_id;
                rem_d   = CW'(steps_x);
                state_d = S_WALK;
              end
            end
            OP_INSERT: begin
              if (pos_x > cnt_x) begin
                res_st_d = ST_RANGE;
              end else if (count_q == CAP_CNT) begin
                res_st_d = ST_FULL;
              end else if (pos_x == cnt_x) begin
                nx_d    = SENT;
                pv_d    = tail_q;
                state_d = S_ALLOC;
              end else begin
                mc.re   = 1'b1;
                mc.ra   = start_id[AW-1:0];
                cur_d   = start_id;
                rem_d   = CW'(steps_x);
                state_d = S_WALK;
              end
            end
            OP_CLEAR: begin
              head_d  = SENT;
              tail_d  = SENT;
              count_d = '0;
              hw_d    = '0;
            end
            default: begin
              res_st_d = ST_OK;
            end
          endcase
        end
      end

      S_WALK: begin
        // read data holds the entry of cur_q
        if (rem_q == '0) begin
          unique case (op_q)
            OP_READ: begin
              res_rd_d = ItemBits'(rd_entry_q.val);
              state_d  = S_FIN;
            end
            OP_DELETE: begin
              nx_d    = rd_entry_q.nxt;
              pv_d    = rd_entry_q.prv;
              state_d = S_DEL1;
            end
            default: begin
              nx_d    = cur_q;
              pv_d    = rd_entry_q.prv;
              state_d = S_ALLOC;
            end
          endcase
        end else begin
          mc.re = 1'b1;
          mc.ra = walk_next[AW-1:0];
          cur_d = walk_next;
          rem_d = rem_q - CW'(1);
        end
      end

      S_ALLOC: begin
        if (pop) begin
          slot_d  = flh_q;
          mc.re   = 1'b1;
          mc.ra   = flh_q[AW-1:0];
          state_d = S_POP;
        end else begin
          slot_d  = LW'(hw_q);
          hw_d    = hw_q + CW'(1);
          state_d = S_INS1;
        end
      end

      S_POP: begin
        flh_d   = rd_entry_q.nxt;
        state_d = S_INS1;
      end

      S_INS1: begin
        mc.we_val = 1'b1;
        mc.we_nxt = 1'b1;
        mc.we_prv = 1'b1;
        mc.wa     = slot_q[AW-1:0];
        mc.wd.val = val_q;
        mc.wd.nxt = nx_q;
        mc.wd.prv = pv_q;
        state_d   = S_INS2;
      end

      S_INS2: begin
        if (pv_q == SENT) begin
          head_d = slot_q;
        end else begin
          mc.we_nxt = 1'b1;
          mc.wa     = pv_q[AW-1:0];
          mc.wd.nxt = slot_q;
        end
        state_d = S_INS3;
      end

      S_INS3: begin
        if (nx_q == SENT) begin
          tail_d = slot_q;
        end else begin
          mc.we_prv = 1'b1;
          mc.wa     = nx_q[AW-1:0];
          mc.wd.prv = slot_q;
        end
        count_d = count_q + CW'(1);
        state_d = S_FIN;
      end

      S_DEL1: begin
        if (nx_q == SENT) begin
          tail_d = pv_q;
        end else begin
          mc.we_prv = 1'b1;
          mc.wa     = nx_q[AW-1:0];
          mc.wd.prv = pv_q;
        end
        state_d = S_DEL2;
      end

      S_DEL2: begin
        if (pv_q == SENT) begin
          head_d = nx_q;
        end else begin
          mc.we_nxt = 1'b1;
          mc.wa     = pv_q[AW-1:0];
          mc.wd.nxt = nx_q;
        end
        state_d = S_DEL3;
      end

      S_DEL3: begin
        // push the freed slot on the free list
        mc.we_nxt = 1'b1;
        mc.wa     = cur_q[AW-1:0];
        mc.wd.nxt = flh_q;
        flh_d     = cur_q;
        count_d   = count_q - CW'(1);
        state_d   = S_FIN;
      end

      S_FIN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = '0;
          m_data_d[OutRdLsb-1:0]         = res_st_q;
          m_data_d[OutLenLsb-1:OutRdLsb] = res_rd_q;
          m_data_d[OutEmpty-1:OutLenLsb] = LenBits'(count_q);
          m_data_d[OutEmpty]             = (count_q == '0);
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= SENT;
      tail_q    <= SENT;
      count_q   <= '0;
      hw_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      hw_q      <= hw_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flh_q    <= flh_d;
    rem_q    <= rem_d;
    op_q     <= op_d;
    front_q  <= front_d;
    cur_q    <= cur_d;
    nx_q     <= nx_d;
    pv_q     <= pv_d;
    slot_q   <= slot_d;
    val_q    <= val_d;
    res_st_q <= res_st_d;
    res_rd_q <= res_rd_d;
    m_data_q <= m_data_d;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CAP_CNT) && (hw_q >= count_q) && (hw_q <= CAP_CNT))
    else $error("entry count or fill count out of bounds");

  a_empty_links: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && count_q == '0) |-> (head_q == SENT && tail_q == SENT))
    else $error("empty list with sentinel not pointing to itself");

  a_walk_no_sentinel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && rem_q != '0) |-> (walk_next != SENT))
    else $error("position walk reached the sentinel");

  a_fin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> (m_valid_q && state_q == S_IDLE))
    else $error("finished request did not load the result register");
`endif

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// stream testbench for the indexed doubly linked list with a queue based list predictor
`default_nettype none

module testbench;
  import idll_pkg::*;

  localparam int HalfPeriod  = 6;
  localparam int CAPACITY    = DefCapacity;
  localparam int ItemTarget  = 1200;
  localparam int CalmTail    = 150;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 60;
  localparam int PrintLimit  = 40;
  localparam int PlanRows    = 24;

  typedef struct packed {
    status_e          status;
    logic [31:0]      read_value;
    logic [LenBits-1:0] length;
    logic             is_empty;
  } result_t;

  typedef struct {
    opcode_e op;
    int      pos;
    logic [31:0] val;
    bit      typed;
    result_t want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [InDataBits-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OutDataBits-1:0] m_axis_tdata;

  // predictor state: list contents in order, front first
  logic [31:0] list_values[$];
  result_t     pending_results[$];
  plan_row_t   directed_plan[PlanRows];

  int  mismatches   = 0;
  int  results_seen = 0;
  int  items_sent   = 0;
  bit  idle_on      = 1'b1;
  bit  hold_req     = 1'b0;
  bit  hold_done    = 1'b0;
  result_t arrived;
  result_t oldest;

  indexed_doubly_linked_list_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #(HalfPeriod) clk_i = 1'b1;
    #(HalfPeriod) clk_i = 1'b0;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < PrintLimit) begin
      $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
    end
    mismatches++;
  endtask

  // list semantics of one request; updates the list and returns its result word
  function automatic result_t apply_to_list(opcode_e op, int pos, logic [31:0] val);
    result_t r;
    int n;
    n = list_values.size();
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_READ: begin
        if (pos < n) r.read_value = list_values[pos];
        else r.status = ST_RANGE;
      end
      OP_INSERT: begin
        if (pos > n) r.status = ST_RANGE;
        else if (n >= CAPACITY) r.status = ST_FULL;
        else list_values.insert(pos, val);
      end
      OP_DELETE: begin
        if (pos < n) list_values.delete(pos);
        else r.status = ST_RANGE;
      end
      default: begin
        list_values.delete();
      end
    endcase
    r.length   = LenBits'(list_values.size());
    r.is_empty = (list_values.size() == 0);
    return r;
  endfunction

  function automatic int pick_pos(int hi);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return hi;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // offers one request word, waits for it to be taken, then records what it should return
  task automatic send_request(opcode_e op, int pos, logic [31:0] val,
                              bit typed = 1'b0, result_t want = '0);
    logic [PosBits-1:0] p7;
    result_t predicted;
    p7 = pos[PosBits-1:0];
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataBits-InUsed){1'b0}}, val, p7, op};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_to_list(op, int'(p7), val);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // result side: random short stalls, and one long hold to back up the input
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      arrived.status     = status_e'(m_axis_tdata[StatusBits-1:0]);
      arrived.read_value = m_axis_tdata[OutRdLsb +: ItemBits];
      arrived.length     = m_axis_tdata[OutLenLsb +: LenBits];
      arrived.is_empty   = m_axis_tdata[OutEmpty];
      if (pending_results.size() == 0) begin
        report_mismatch("word with nothing pending", longint'(m_axis_tdata), 0);
      end else begin
        oldest = pending_results.pop_front();
        if (arrived.status != oldest.status)
          report_mismatch("status", longint'(arrived.status), longint'(oldest.status));
        if (arrived.read_value != oldest.read_value)
          report_mismatch("read_value", longint'(arrived.read_value),
                          longint'(oldest.read_value));
        if (arrived.length != oldest.length)
          report_mismatch("length", longint'(arrived.length), longint'(oldest.length));
        if (arrived.is_empty != oldest.is_empty)
          report_mismatch("is_empty", longint'(arrived.is_empty), longint'(oldest.is_empty));
      end
      results_seen++;
    end
  end

  initial begin
    #(2 * HalfPeriod * 600_000);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int n;
    int k;
    int target;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;

    directed_plan = '{
      '{OP_READ,     0, 32'h0,         1'b1, '{ST_RANGE, 32'h0,         7'd0, 1'b1}},
      '{OP_DELETE,   0, 32'h0,         1'b1, '{ST_RANGE, 32'h0,         7'd0, 1'b1}},
      '{OP_INSERT,   1, 32'h1234_5678, 1'b1, '{ST_RANGE, 32'h0,         7'd0, 1'b1}},
      '{OP_INSERT, 127, 32'hFFFF_FFFF, 1'b1, '{ST_RANGE, 32'h0,         7'd0, 1'b1}},
      '{OP_INSERT,   0, 32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'h0,         7'd1, 1'b0}},
      '{OP_INSERT,   1, 32'h0,         1'b1, '{ST_OK,    32'h0,         7'd2, 1'b0}},
      '{OP_INSERT,   1, 32'hA5A5_5A5A, 1'b1, '{ST_OK,    32'h0,         7'd3, 1'b0}},
      '{OP_READ,     0, 32'h0,         1'b1, '{ST_OK,    32'hFFFF_FFFF, 7'd3, 1'b0}},
      '{OP_READ,     1, 32'h0,         1'b1, '{ST_OK,    32'hA5A5_5A5A, 7'd3, 1'b0}},
      '{OP_READ,     2, 32'h0,         1'b1, '{ST_OK,    32'h0,         7'd3, 1'b0}},
      '{OP_READ,     3, 32'h0,         1'b1, '{ST_RANGE, 32'h0,         7'd3, 1'b0}},
      '{OP_READ,   127, 32'h0,         1'b1, '{ST_RANGE, 32'h0,         7'd3, 1'b0}},
      '{OP_DELETE,   3, 32'h0,         1'b1, '{ST_RANGE, 32'h0,         7'd3, 1'b0}},
      '{OP_DELETE,   1, 32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'h0,         7'd2, 1'b0}},
      '{OP_INSERT,   2, 32'h5A5A_A5A5, 1'b0, '{ST_OK,    32'h0,         7'd0, 1'b0}},
      '{OP_READ,     2, 32'h0,         1'b0, '{ST_OK,    32'h0,         7'd0, 1'b0}},
      '{OP_DELETE,   0, 32'h0,         1'b0, '{ST_OK,    32'h0,         7'd0, 1'b0}},
      '{OP_READ,     0, 32'h0,         1'b0, '{ST_OK,    32'h0,         7'd0, 1'b0}},
      '{OP_INSERT,   2, 32'h1234_5678, 1'b0, '{ST_OK,    32'h0,         7'd0, 1'b0}},
      '{OP_CLEAR,  127, 32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'h0,         7'd0, 1'b1}},
      '{OP_READ,     0, 32'h0,         1'b1, '{ST_RANGE, 32'h0,         7'd0, 1'b1}},
      '{OP_CLEAR,    0, 32'h0,         1'b1, '{ST_OK,    32'h0,         7'd0, 1'b1}},
      '{OP_INSERT,   0, 32'h0000_0001, 1'b1, '{ST_OK,    32'h0,         7'd1, 1'b0}},
      '{OP_DELETE,   0, 32'h0,         1'b1, '{ST_OK,    32'h0,         7'd0, 1'b1}}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      send_request(directed_plan[i].op, directed_plan[i].pos, directed_plan[i].val,
                   directed_plan[i].typed, directed_plan[i].want);
    end

    while (items_sent < ItemTarget) begin
      idle_on = (items_sent < ItemTarget - CalmTail);
      if (!hold_done && items_sent >= 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // grow
          repeat ($urandom_range(4, 40)) begin
            send_request(OP_INSERT, pick_pos(list_values.size()), pick_value());
          end
        end
        4: begin
          // fill the pool, then push past it
          while (list_values.size() < CAPACITY) begin
            send_request(OP_INSERT, pick_pos(list_values.size()), pick_value());
          end
          repeat (3) send_request(OP_INSERT, $urandom_range(0, CAPACITY), pick_value());
          send_request(OP_INSERT, $urandom_range(CAPACITY + 1, 127), pick_value());
          send_request(OP_READ, CAPACITY - 1, pick_value());
          send_request(OP_READ, CAPACITY / 2, pick_value());
        end
        5, 6, 7: begin
          repeat ($urandom_range(10, 40)) begin
            n = list_values.size();
            k = $urandom_range(0, 99);
            if (k < 2) begin
              send_request(OP_CLEAR, $urandom_range(0, 127), pick_value());
            end else if (k < 12) begin
              // out of range or arbitrary positions
              send_request(opcode_e'($urandom_range(0, 2)), $urandom_range(0, 127),
                           pick_value());
            end else if (k < 50) begin
              send_request(OP_READ, (n > 0) ? pick_pos(n - 1) : 0, pick_value());
            end else if (k < 75) begin
              send_request(OP_INSERT, pick_pos(n), pick_value());
            end else begin
              send_request(OP_DELETE, (n > 0) ? pick_pos(n - 1) : 0, pick_value());
            end
          end
        end
        8: begin
          // drain
          target = $urandom_range(0, list_values.size());
          while (list_values.size() > target) begin
            send_request(OP_DELETE, pick_pos(list_values.size() - 1), pick_value());
          end
          if (list_values.size() == 0) begin
            send_request(OP_READ, 0, pick_value());
            send_request(OP_DELETE, 0, pick_value());
          end
        end
        default: begin
          send_request(OP_CLEAR, $urandom_range(0, 127), pick_value());
          send_request(OP_READ, $urandom_range(0, 127), pick_value());
          send_request(OP_INSERT, 0, pick_value());
        end
      endcase
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
